/* sv/bstd_pkg.sv */
// Shared types, codes and constants for the BER scalar TLV decoder.
// No dependencies.
package bstd_pkg;

    // Longest long-form length field accepted (count of length bytes)
    localparam int MAX_LENGTH_BYTES = 8;

    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_INTEGER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_COUNTER32 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_GAUGE32   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_TIMETICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_COUNTER64 = 3'd4;

    // Tag reset values
    localparam logic [7:0] RST_TAG_INTEGER   = 8'd2;
    localparam logic [7:0] RST_TAG_COUNTER32 = 8'd65;
    localparam logic [7:0] RST_TAG_GAUGE32   = 8'd66;
    localparam logic [7:0] RST_TAG_TIMETICKS = 8'd67;
    localparam logic [7:0] RST_TAG_COUNTER64 = 8'd70;

    // Value kinds
    localparam logic [2:0] K_INTEGER   = 3'd0;
    localparam logic [2:0] K_COUNTER32 = 3'd1;
    localparam logic [2:0] K_GAUGE32   = 3'd2;
    localparam logic [2:0] K_TIMETICKS = 3'd3;
    localparam logic [2:0] K_COUNTER64 = 3'd4;

    // Error codes
    localparam logic [2:0] E_OK     = 3'd0;
    localparam logic [2:0] E_TAG    = 3'd1;
    localparam logic [2:0] E_LENENC = 3'd2;
    localparam logic [2:0] E_CLEN   = 3'd3;
    localparam logic [2:0] E_NONMIN = 3'd4;
    localparam logic [2:0] E_TRUNC  = 3'd5;

    typedef enum logic [1:0] {
        PH_TAG,
        PH_LEN,
        PH_LLONG,
        PH_CONT
    } t_phase;

    // Largest content length allowed per kind
    function automatic logic [3:0] max_len_of(input logic [2:0] kind);
        logic [3:0] len;
        case (kind)
            K_INTEGER:   len = 4'd4;
            K_COUNTER64: len = 4'd9;
            default:     len = 4'd5;
        endcase
        return len;
    endfunction

endpackage

/* sv/ber_scalar_tlv_decoder.sv */
// Streaming decoder for BER scalar TLVs (INTEGER, Counter32, Gauge32,
// TimeTicks, Counter64), one byte per request. Depends on bstd_pkg.
// Result path: an accepted request is held in the input register, then decoded
// into the result register; a result waiting downstream can hold it there.
// Throughput: one byte per cycle while no result is held up downstream; the input
// register keeps taking bytes that produce no result while a result waits downstream.
// Reset: synchronous, active low; tags return to their defaults and the
// decoder expects a tag byte.
module ber_scalar_tlv_decoder
    import bstd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // byte stream in
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_buffer_end,

    // results out
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [63:0]          o_value,
    output logic [2:0]           o_value_kind,
    output logic [2:0]           o_error_code,

    // configuration writes
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    // ------------------------------------------------------------------
    // Tag registers
    // ------------------------------------------------------------------
    logic [7:0] r_tag_int, r_tag_c32, r_tag_g32, r_tag_tt, r_tag_c64;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_int <= RST_TAG_INTEGER;
            r_tag_c32 <= RST_TAG_COUNTER32;
            r_tag_g32 <= RST_TAG_GAUGE32;
            r_tag_tt  <= RST_TAG_TIMETICKS;
            r_tag_c64 <= RST_TAG_COUNTER64;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TAG_INTEGER:   r_tag_int <= i_cfg_data;
                CFG_TAG_COUNTER32: r_tag_c32 <= i_cfg_data;
                CFG_TAG_GAUGE32:   r_tag_g32 <= i_cfg_data;
                CFG_TAG_TIMETICKS: r_tag_tt  <= i_cfg_data;
                CFG_TAG_COUNTER64: r_tag_c64 <= i_cfg_data;
                default: ;  // unused indexes are ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic       r_in_vld;
    logic [7:0] r_in_data;
    logic       r_in_last;
    logic       in_accept;
    logic       advance;    // held byte goes through the decoder this cycle
    logic       res_vld;    // held byte completes or fails a TLV

    assign in_accept  = i_in_valid && !o_in_stall;
    // A byte that yields a result needs room in the result register.
    assign advance    = r_in_vld && (!res_vld || !o_out_valid || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_accept) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_buffer_end;
        end
    end

    // ------------------------------------------------------------------
    // Decoder state
    // ------------------------------------------------------------------
    t_phase      r_phase,      n_phase;
    logic [2:0]  r_kind,       n_kind;
    logic [3:0]  r_len_left,   n_len_left;    // long-form length bytes still due
    logic        r_len_first,  n_len_first;   // next length byte is the first one
    logic [3:0]  r_cont_total, n_cont_total;
    logic [3:0]  r_cont_left,  n_cont_left;
    logic [7:0]  r_first_byte, n_first_byte;
    logic [63:0] r_acc,        n_acc;

    logic [63:0] res_val;
    logic [2:0]  res_err;
    logic        done;          // TLV finished: back to tag phase

    logic [7:0]  d;
    logic        last;
    logic [3:0]  max_len;
    logic [3:0]  cont_idx;
    logic [63:0] acc_base;

    assign d        = r_in_data;
    assign last     = r_in_last;
    assign max_len  = max_len_of(r_kind);
    assign cont_idx = r_cont_total - r_cont_left;

    always_comb begin
        n_phase      = r_phase;
        n_kind       = r_kind;
        n_len_left   = r_len_left;
        n_len_first  = r_len_first;
        n_cont_total = r_cont_total;
        n_cont_left  = r_cont_left;
        n_first_byte = r_first_byte;
        n_acc        = r_acc;
        res_vld      = 1'b0;
        res_val      = '0;
        res_err      = E_OK;
        done         = 1'b0;
        acc_base     = r_acc;

        case (r_phase)
            PH_TAG: begin
                // first match wins when tags are duplicated
                n_phase = PH_LEN;
                if (d == r_tag_int)      n_kind = K_INTEGER;
                else if (d == r_tag_c32) n_kind = K_COUNTER32;
                else if (d == r_tag_g32) n_kind = K_GAUGE32;
                else if (d == r_tag_tt)  n_kind = K_TIMETICKS;
                else if (d == r_tag_c64) n_kind = K_COUNTER64;
                else begin
                    n_kind  = K_INTEGER;
                    res_vld = 1'b1;
                    res_err = E_TAG;
                end
                if (!res_vld && last) begin
                    res_vld = 1'b1;
                    res_err = E_TRUNC;
                end
            end

            PH_LEN: begin
                if (!d[7]) begin
                    // short form
                    if (d[6:0] == 7'd0 || d[6:0] > {3'b000, max_len}) begin
                        res_vld = 1'b1;
                        res_err = E_CLEN;
                    end else begin
                        n_cont_total = d[3:0];
                        n_cont_left  = d[3:0];
                        n_phase      = PH_CONT;
                        if (last) begin
                            res_vld = 1'b1;
                            res_err = E_TRUNC;
                        end
                    end
                end else if (d[6:0] == 7'd0 || d[6:0] > 7'(MAX_LENGTH_BYTES)) begin
                    // indefinite form or too many length bytes
                    res_vld = 1'b1;
                    res_err = E_LENENC;
                end else begin
                    n_len_left  = d[3:0];
                    n_len_first = 1'b1;
                    n_phase     = PH_LLONG;
                    if (last) begin
                        res_vld = 1'b1;
                        res_err = E_TRUNC;
                    end
                end
            end

            PH_LLONG: begin
                // A multi-byte length starts nonzero, so it is at least 256 and
                // always exceeds every kind's limit. Only a single length byte
                // can land below 128.
                n_len_left  = r_len_left - 4'd1;
                n_len_first = 1'b0;
                if (r_len_first && r_len_left > 4'd1 && d == 8'h00) begin
                    res_vld = 1'b1;
                    res_err = E_NONMIN;
                end else if (r_len_left == 4'd1) begin
                    res_vld = 1'b1;
                    res_err = (r_len_first && !d[7]) ? E_NONMIN : E_CLEN;
                end else if (last) begin
                    res_vld = 1'b1;
                    res_err = E_TRUNC;
                end
            end

            PH_CONT: begin
                if (cont_idx == 4'd0) begin
                    n_first_byte = d;
                    // full-width unsigned content must open with a zero byte
                    if (r_kind != K_INTEGER && r_cont_total == max_len && d != 8'h00) begin
                        res_vld = 1'b1;
                        res_err = E_CLEN;
                    end
                    acc_base = (r_kind == K_INTEGER && d[7]) ? '1 : '0;
                end else if (cont_idx == 4'd1) begin
                    // redundant leading 0x00, or 0xFF for signed values
                    if (r_first_byte == 8'h00 && !d[7]) begin
                        res_vld = 1'b1;
                        res_err = E_NONMIN;
                    end else if (r_kind == K_INTEGER && r_first_byte == 8'hFF && d[7]) begin
                        res_vld = 1'b1;
                        res_err = E_NONMIN;
                    end
                end
                if (!res_vld) begin
                    n_acc       = {acc_base[55:0], d};
                    n_cont_left = r_cont_left - 4'd1;
                    if (r_cont_left == 4'd1) begin
                        res_vld = 1'b1;
                        res_val = (r_kind == K_COUNTER64) ? n_acc : {32'h0, n_acc[31:0]};
                    end else if (last) begin
                        res_vld = 1'b1;
                        res_err = E_TRUNC;
                    end
                end
            end

            default: begin
                done = 1'b1;
            end
        endcase

        if (res_vld) begin
            done = 1'b1;
        end
        if (done) begin
            n_phase      = PH_TAG;
            n_len_left   = '0;
            n_len_first  = 1'b0;
            n_cont_total = '0;
            n_cont_left  = '0;
            n_first_byte = '0;
            n_acc        = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_TAG;
            r_kind       <= K_INTEGER;
            r_len_left   <= '0;
            r_len_first  <= 1'b0;
            r_cont_total <= '0;
            r_cont_left  <= '0;
            r_first_byte <= '0;
            r_acc        <= '0;
        end else if (advance) begin
            r_phase      <= n_phase;
            r_kind       <= n_kind;
            r_len_left   <= n_len_left;
            r_len_first  <= n_len_first;
            r_cont_total <= n_cont_total;
            r_cont_left  <= n_cont_left;
            r_first_byte <= n_first_byte;
            r_acc        <= n_acc;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic        r_out_vld;
    logic [63:0] r_out_value;
    logic [2:0]  r_out_kind;
    logic [2:0]  r_out_err;
    logic        res_load;

    assign res_load = advance && res_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_value <= res_val;
            r_out_kind  <= n_kind;
            r_out_err   <= res_err;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_value      = r_out_value;
    assign o_value_kind = r_out_kind;
    assign o_error_code = r_out_err;

`ifndef ASSERT_OFF
    // content phase always has bytes still due
    a_cont_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_CONT |-> (r_cont_left != 4'd0 && r_cont_left <= r_cont_total))
        else $error("content counter out of range");

    a_len_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_LLONG |->
            (r_len_left != 4'd0 && r_len_left <= 4'(MAX_LENGTH_BYTES)))
        else $error("length byte counter out of range");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_code != E_OK) |-> o_value == 64'h0)
        else $error("error result carries a nonzero value");

    a_res_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |=> o_out_valid)
        else $error("decoded result lost");

    a_tag_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_TAG |-> (r_acc == 64'h0 && r_cont_left == 4'd0))
        else $error("stale TLV state in tag phase");
`endif

endmodule

/* sim/tb.sv */
// Self-checking testbench for ber_scalar_tlv_decoder: a byte-level predictor
// and a result book in a small class, plain tasks driving requests and tags.
// Depends on bstd_pkg and the decoder RTL.
module tb
    import bstd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Request-to-result depth of the block, two register stages.
    localparam int PIPE_DEPTH  = 2;
    // Cycles without any handshake before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Random requests per tag setting.
    localparam int SEG_ITEMS   = 405;

    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  kind;
        logic [2:0]  err;
    } t_tlv_result;

    // Predicts decoder results byte by byte and holds them until the block
    // delivers its own.
    class tlv_result_book;
        logic [7:0]  tag_of_reg [5];
        t_phase      phase;
        logic [2:0]  kind_held;
        logic [3:0]  len_bytes_left;
        logic [63:0] len_accum;
        logic [3:0]  cont_left;
        logic [3:0]  cont_total;
        logic [7:0]  first_byte;
        logic [63:0] val_accum;
        t_tlv_result pending_values [$];
        int          mismatches;

        function new();
            tag_of_reg[CFG_TAG_INTEGER]   = RST_TAG_INTEGER;
            tag_of_reg[CFG_TAG_COUNTER32] = RST_TAG_COUNTER32;
            tag_of_reg[CFG_TAG_GAUGE32]   = RST_TAG_GAUGE32;
            tag_of_reg[CFG_TAG_TIMETICKS] = RST_TAG_TIMETICKS;
            tag_of_reg[CFG_TAG_COUNTER64] = RST_TAG_COUNTER64;
            kind_held  = K_INTEGER;
            mismatches = 0;
            clear_tlv();
        endfunction

        function void set_tag(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            tag_of_reg[idx] = val;
        endfunction

        function int outstanding();
            return pending_values.size();
        endfunction

        function logic [3:0] kind_limit(logic [2:0] kind);
            case (kind)
                K_INTEGER:   return 4'd4;
                K_COUNTER64: return 4'd9;
                default:     return 4'd5;
            endcase
        endfunction

        function void clear_tlv();
            phase          = PH_TAG;
            len_bytes_left = '0;
            len_accum      = '0;
            cont_left      = '0;
            cont_total     = '0;
            first_byte     = '0;
            val_accum      = '0;
        endfunction

        function void post(logic [63:0] value, logic [2:0] kind, logic [2:0] err);
            t_tlv_result r;
            r.value = value;
            r.kind  = kind;
            r.err   = err;
            pending_values.push_back(r);
            clear_tlv();
        endfunction

        function void post_error(logic [2:0] err);
            post('0, kind_held, err);
        endfunction

        function void accept_length(logic [63:0] len, logic last);
            if (len == 0 || len > kind_limit(kind_held)) begin
                post_error(E_CLEN);
            end else begin
                cont_total = len[3:0];
                cont_left  = len[3:0];
                phase      = PH_CONT;
                if (last) post_error(E_TRUNC);
            end
        endfunction

        // One accepted request.
        function void decode_byte(logic [7:0] b, logic last);
            logic [3:0]  idx;
            logic [63:0] v;
            case (phase)
                PH_TAG: begin
                    // first matching register wins when tags are duplicated
                    if (b == tag_of_reg[CFG_TAG_INTEGER])        kind_held = K_INTEGER;
                    else if (b == tag_of_reg[CFG_TAG_COUNTER32]) kind_held = K_COUNTER32;
                    else if (b == tag_of_reg[CFG_TAG_GAUGE32])   kind_held = K_GAUGE32;
                    else if (b == tag_of_reg[CFG_TAG_TIMETICKS]) kind_held = K_TIMETICKS;
                    else if (b == tag_of_reg[CFG_TAG_COUNTER64]) kind_held = K_COUNTER64;
                    else begin
                        kind_held = K_INTEGER;
                        post('0, K_INTEGER, E_TAG);
                        return;
                    end
                    phase = PH_LEN;
                    if (last) post_error(E_TRUNC);
                end
                PH_LEN: begin
                    if (!b[7]) begin
                        accept_length({56'd0, b}, last);
                    end else if (b == 8'h80) begin
                        post_error(E_LENENC);
                    end else if (b[6:0] > MAX_LENGTH_BYTES) begin
                        post_error(E_LENENC);
                    end else begin
                        len_bytes_left = b[3:0];
                        len_accum      = '0;
                        phase          = PH_LLONG;
                        if (last) post_error(E_TRUNC);
                    end
                end
                PH_LLONG: begin
                    if (len_accum == 0 && len_bytes_left > 1 && b == 8'h00) begin
                        post_error(E_NONMIN);
                        return;
                    end
                    len_accum = {len_accum[55:0], b};
                    if (len_bytes_left > 0) len_bytes_left--;
                    if (len_bytes_left == 0) begin
                        if (len_accum < 128) post_error(E_NONMIN);
                        else accept_length(len_accum, last);
                    end else if (last) begin
                        post_error(E_TRUNC);
                    end
                end
                PH_CONT: begin
                    idx = cont_total - cont_left;
                    if (idx == 0) begin
                        first_byte = b;
                        // full-length unsigned content must open with a zero
                        if (kind_held != K_INTEGER && cont_total == kind_limit(kind_held)
                                && b != 8'h00) begin
                            post_error(E_CLEN);
                            return;
                        end
                        val_accum = (kind_held == K_INTEGER && b[7]) ? '1 : '0;
                    end else if (idx == 1) begin
                        if (first_byte == 8'h00 && !b[7]) begin
                            post_error(E_NONMIN);
                            return;
                        end
                        if (kind_held == K_INTEGER && first_byte == 8'hFF && b[7]) begin
                            post_error(E_NONMIN);
                            return;
                        end
                    end
                    val_accum = {val_accum[55:0], b};
                    if (cont_left > 0) cont_left--;
                    if (cont_left == 0) begin
                        v = val_accum;
                        if (kind_held != K_COUNTER64) v[63:32] = '0;
                        post(v, kind_held, E_OK);
                    end else if (last) begin
                        post_error(E_TRUNC);
                    end
                end
            endcase
        endfunction

        function void report(string what, t_tlv_result want, t_tlv_result got);
            mismatches++;
            if (mismatches <= 10)
                $display("%s: expected value %h kind %0d error %0d, got value %h kind %0d error %0d",
                         what, want.value, want.kind, want.err, got.value, got.kind, got.err);
        endfunction

        function void check_result(logic [63:0] value, logic [2:0] kind, logic [2:0] err);
            t_tlv_result want;
            t_tlv_result got;
            got.value = value;
            got.kind  = kind;
            got.err   = err;
            if (pending_values.size() == 0) begin
                report("result with nothing pending", '0, got);
            end else begin
                want = pending_values.pop_front();
                if (want.value !== value || want.kind !== kind || want.err !== err)
                    report("result mismatch", want, got);
            end
        endfunction
    endclass

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_stall;
    logic [7:0]           i_data_byte  = '0;
    logic                 i_buffer_end = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall  = 1'b0;
    logic [63:0]          o_value;
    logic [2:0]           o_value_kind;
    logic [2:0]           o_error_code;
    logic                 i_cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [7:0]           i_cfg_data   = '0;

    tlv_result_book book = new();
    logic [8:0]     plan [$];       // queued requests: {buffer_end, data_byte}
    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;
    int             quiet_cycles   = 0;

    // Directed opening, bit 8 is buffer_end. Tags are the reset values.
    localparam logic [8:0] DIRECTED [30] = '{
        // integer -1 from one sign-extended byte
        {1'b0, RST_TAG_INTEGER}, 9'h001, 9'h0FF,
        // zero content length
        {1'b0, RST_TAG_INTEGER}, 9'h000,
        // full-length counter64 whose first byte is not zero
        {1'b0, RST_TAG_COUNTER64}, 9'h009, 9'h0FF,
        // redundant leading zero
        {1'b0, RST_TAG_COUNTER32}, 9'h002, 9'h000, 9'h07F,
        // redundant leading 0xFF on an integer
        {1'b0, RST_TAG_INTEGER}, 9'h002, 9'h0FF, 9'h080,
        // unknown tag
        9'h000,
        // indefinite length on the buffer's last byte: the length error wins
        {1'b0, RST_TAG_GAUGE32}, 9'h180,
        // more length bytes than allowed
        {1'b0, RST_TAG_TIMETICKS}, 9'h089,
        // leading zero in a long-form length
        {1'b0, RST_TAG_COUNTER32}, 9'h082, 9'h000,
        // long form used for a length below 128
        {1'b0, RST_TAG_GAUGE32}, 9'h081, 9'h07F,
        // buffer ends inside the content
        {1'b0, RST_TAG_COUNTER64}, 9'h003, 9'h112
    };

    ber_scalar_tlv_decoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_buffer_end (i_buffer_end),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value      (o_value),
        .o_value_kind (o_value_kind),
        .o_error_code (o_error_code),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Both handshakes are sampled at the edge where they complete; every
    // signal involved was last updated at an earlier edge, so no race.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            book.decode_byte(i_data_byte, i_buffer_end);
        if (i_rst_n && o_out_valid && !i_out_stall)
            book.check_result(o_value, o_value_kind, o_error_code);
        if (i_rst_n && ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Hang detection.
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("[ber_scalar_tlv_decoder] ERROR");
        $finish;
    end

    // Present one request and hold it until taken. The idle decision comes
    // before valid rises, so valid never reacts to stall.
    task automatic send_byte(input logic [8:0] item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= item[7:0];
        i_buffer_end <= item[8];
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Stop sending until every predicted result is in, then stay idle while the
    // pipeline clears.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (book.outstanding() != 0);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic write_tag(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        book.set_tag(idx, val);
    endtask

    task automatic load_tags(input logic [7:0] t_int, input logic [7:0] t_c32,
                             input logic [7:0] t_g32, input logic [7:0] t_tt,
                             input logic [7:0] t_c64);
        write_tag(CFG_TAG_INTEGER, t_int);
        write_tag(CFG_TAG_COUNTER32, t_c32);
        write_tag(CFG_TAG_GAUGE32, t_g32);
        write_tag(CFG_TAG_TIMETICKS, t_tt);
        write_tag(CFG_TAG_COUNTER64, t_c64);
        i_cfg_wr_en <= 1'b0;
    endtask

    // A rare buffer end on any byte gives truncation at every position.
    function automatic void plan_byte(input logic [7:0] b);
        plan.push_back({($urandom_range(49) == 0), b});
    endfunction

    // Queue one TLV: mostly well-formed with random content, the rest bad
    // lengths, long forms and plain noise.
    task automatic queue_tlv();
        int         shape;
        int         count;
        logic [2:0] kind;
        logic [3:0] limit;
        logic [7:0] b;
        logic [8:0] tail;
        shape = $urandom_range(99);
        kind  = 3'($urandom_range(4));
        limit = book.kind_limit(kind);
        plan_byte(($urandom_range(19) == 0) ? 8'($urandom) : book.tag_of_reg[kind]);
        if (shape < 72) begin
            count = $urandom_range(limit, 1);
            plan_byte(8'(count));
            for (int i = 0; i < count; i++) begin
                b = 8'($urandom);
                if (i == 0) begin
                    // favor the bytes that matter for minimal encoding
                    case ($urandom_range(3))
                        0:       b = 8'h00;
                        1:       b = 8'hFF;
                        default: ;
                    endcase
                    if (kind != K_INTEGER && count == limit && $urandom_range(4) != 0)
                        b = 8'h00;
                end
                plan_byte(b);
            end
        end else if (shape < 80) begin
            // short length, often out of range for the kind
            plan_byte(8'($urandom_range(127)));
        end else if (shape < 92) begin
            count = $urandom_range(15);
            plan_byte(8'h80 | 8'(count));
            for (int i = 0; i < count && i < MAX_LENGTH_BYTES; i++)
                plan_byte(($urandom_range(2) == 0) ? 8'h00 : 8'($urandom));
        end else begin
            count = $urandom_range(4, 1);
            repeat (count) plan_byte(8'($urandom));
        end
        // sometimes the buffer ends exactly on this TLV
        if ($urandom_range(6) == 0) begin
            tail = plan.pop_back();
            plan.push_back({1'b1, tail[7:0]});
        end
    endtask

    // Random traffic under the current tags, with one full pause midway.
    task automatic run_segment(input int items);
        int sent;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < items) begin
            if (!paused && sent >= items / 2) begin
                drain();
                paused = 1'b1;
            end
            queue_tlv();
            while (plan.size() > 0) begin
                send_byte(plan.pop_front());
                sent++;
            end
        end
    endtask

    initial begin
        logic [7:0] rt [5];
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset tags; sender idles a little, receiver a lot
        send_idle_pct  = 16;
        recv_stall_pct = 70;
        foreach (DIRECTED[i]) send_byte(DIRECTED[i]);
        run_segment(SEG_ITEMS);

        // extremes, with integer and gauge32 sharing a tag
        drain();
        load_tags(8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F);
        send_idle_pct  = 70;
        recv_stall_pct = 16;
        run_segment(SEG_ITEMS);

        drain();
        load_tags(8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'hFB);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_segment(SEG_ITEMS);

        // random tags, some copied from earlier registers
        drain();
        rt[0] = 8'($urandom);
        for (int i = 1; i < 5; i++)
            rt[i] = ($urandom_range(3) == 0) ? rt[$urandom_range(i - 1)] : 8'($urandom);
        load_tags(rt[0], rt[1], rt[2], rt[3], rt[4]);
        run_segment(SEG_ITEMS);

        drain();
        if (book.mismatches == 0 && book.outstanding() == 0)
            $display("[ber_scalar_tlv_decoder] OK");
        else
            $display("[ber_scalar_tlv_decoder] ERROR");
        $finish;
    end

endmodule
